// File: hdl/fg3_pkg.sv
package fg3_pkg;

	localparam logic [11:0] MaxLineWidth = 12'd2048;
	localparam logic [11:0] LineWidthReset = 12'd1728;
	localparam logic [5:0] FillLevel = 6'd20;
	localparam logic [2:0] MaxEvents = 3'd4;
	localparam logic [11:0] EolRun = 12'hFFF;
	localparam int NumColorCodes = 91;
	localparam int NumSharedCodes = 14;

	typedef enum logic [1:0] {
		EV_RUN,
		EV_LINE,
		EV_INVALID,
		EV_PAGE
	} event_kind_t;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_SEEK,
		MODE_FILL
	} mode_t;

	typedef enum logic {
		ENG_IDLE,
		ENG_RUN
	} eng_state_t;

	typedef enum logic {
		CFG_REVERSE,
		CFG_WIDTH
	} cfg_reg_t;

	typedef struct packed {
		event_kind_t kind;
		logic color;
		logic [11:0] start;
		logic [11:0] length;
		logic [15:0] row;
		logic last;
	} event_t;

	// Code words are written first bit on the left, as transmitted.
	typedef struct packed {
		logic [12:0] pat;
		logic [3:0] len;
		logic [11:0] run;
	} code_t;

	typedef struct packed {
		logic found;
		logic eol;
		logic [3:0] len;
		logic [11:0] run;
	} lookup_t;

	localparam code_t WhiteCodes [NumColorCodes] = '{
		'{13'b00110101,4'd8,12'd0}, '{13'b000111,4'd6,12'd1}, '{13'b0111,4'd4,12'd2},
		'{13'b1000,4'd4,12'd3}, '{13'b1011,4'd4,12'd4}, '{13'b1100,4'd4,12'd5},
		'{13'b1110,4'd4,12'd6}, '{13'b1111,4'd4,12'd7}, '{13'b10011,4'd5,12'd8},
		'{13'b10100,4'd5,12'd9}, '{13'b00111,4'd5,12'd10}, '{13'b01000,4'd5,12'd11},
		'{13'b001000,4'd6,12'd12}, '{13'b000011,4'd6,12'd13}, '{13'b110100,4'd6,12'd14},
		'{13'b110101,4'd6,12'd15}, '{13'b101010,4'd6,12'd16}, '{13'b101011,4'd6,12'd17},
		'{13'b0100111,4'd7,12'd18}, '{13'b0001100,4'd7,12'd19}, '{13'b0001000,4'd7,12'd20},
		'{13'b0010111,4'd7,12'd21}, '{13'b0000011,4'd7,12'd22}, '{13'b0000100,4'd7,12'd23},
		'{13'b0101000,4'd7,12'd24}, '{13'b0101011,4'd7,12'd25}, '{13'b0010011,4'd7,12'd26},
		'{13'b0100100,4'd7,12'd27}, '{13'b0011000,4'd7,12'd28}, '{13'b00000010,4'd8,12'd29},
		'{13'b00000011,4'd8,12'd30}, '{13'b00011010,4'd8,12'd31}, '{13'b00011011,4'd8,12'd32},
		'{13'b00010010,4'd8,12'd33}, '{13'b00010011,4'd8,12'd34}, '{13'b00010100,4'd8,12'd35},
		'{13'b00010101,4'd8,12'd36}, '{13'b00010110,4'd8,12'd37}, '{13'b00010111,4'd8,12'd38},
		'{13'b00101000,4'd8,12'd39}, '{13'b00101001,4'd8,12'd40}, '{13'b00101010,4'd8,12'd41},
		'{13'b00101011,4'd8,12'd42}, '{13'b00101100,4'd8,12'd43}, '{13'b00101101,4'd8,12'd44},
		'{13'b00000100,4'd8,12'd45}, '{13'b00000101,4'd8,12'd46}, '{13'b00001010,4'd8,12'd47},
		'{13'b00001011,4'd8,12'd48}, '{13'b01010010,4'd8,12'd49}, '{13'b01010011,4'd8,12'd50},
		'{13'b01010100,4'd8,12'd51}, '{13'b01010101,4'd8,12'd52}, '{13'b00100100,4'd8,12'd53},
		'{13'b00100101,4'd8,12'd54}, '{13'b01011000,4'd8,12'd55}, '{13'b01011001,4'd8,12'd56},
		'{13'b01011010,4'd8,12'd57}, '{13'b01011011,4'd8,12'd58}, '{13'b01001010,4'd8,12'd59},
		'{13'b01001011,4'd8,12'd60}, '{13'b00110010,4'd8,12'd61}, '{13'b00110011,4'd8,12'd62},
		'{13'b00110100,4'd8,12'd63},
		'{13'b11011,4'd5,12'd64}, '{13'b10010,4'd5,12'd128}, '{13'b010111,4'd6,12'd192},
		'{13'b0110111,4'd7,12'd256}, '{13'b00110110,4'd8,12'd320},
		'{13'b00110111,4'd8,12'd384}, '{13'b01100100,4'd8,12'd448},
		'{13'b01100101,4'd8,12'd512}, '{13'b01101000,4'd8,12'd576},
		'{13'b01100111,4'd8,12'd640}, '{13'b011001100,4'd9,12'd704},
		'{13'b011001101,4'd9,12'd768}, '{13'b011010010,4'd9,12'd832},
		'{13'b011010011,4'd9,12'd896}, '{13'b011010100,4'd9,12'd960},
		'{13'b011010101,4'd9,12'd1024}, '{13'b011010110,4'd9,12'd1088},
		'{13'b011010111,4'd9,12'd1152}, '{13'b011011000,4'd9,12'd1216},
		'{13'b011011001,4'd9,12'd1280}, '{13'b011011010,4'd9,12'd1344},
		'{13'b011011011,4'd9,12'd1408}, '{13'b010011000,4'd9,12'd1472},
		'{13'b010011001,4'd9,12'd1536}, '{13'b010011010,4'd9,12'd1600},
		'{13'b011000,4'd6,12'd1664}, '{13'b010011011,4'd9,12'd1728}
	};

	localparam code_t BlackCodes [NumColorCodes] = '{
		'{13'b0000110111,4'd10,12'd0}, '{13'b010,4'd3,12'd1}, '{13'b11,4'd2,12'd2},
		'{13'b10,4'd2,12'd3}, '{13'b011,4'd3,12'd4}, '{13'b0011,4'd4,12'd5},
		'{13'b0010,4'd4,12'd6}, '{13'b00011,4'd5,12'd7}, '{13'b000101,4'd6,12'd8},
		'{13'b000100,4'd6,12'd9}, '{13'b0000100,4'd7,12'd10}, '{13'b0000101,4'd7,12'd11},
		'{13'b0000111,4'd7,12'd12}, '{13'b00000100,4'd8,12'd13}, '{13'b00000111,4'd8,12'd14},
		'{13'b000011000,4'd9,12'd15}, '{13'b0000010111,4'd10,12'd16},
		'{13'b0000011000,4'd10,12'd17}, '{13'b0000001000,4'd10,12'd18},
		'{13'b00001100111,4'd11,12'd19}, '{13'b00001101000,4'd11,12'd20},
		'{13'b00001101100,4'd11,12'd21}, '{13'b00000110111,4'd11,12'd22},
		'{13'b00000101000,4'd11,12'd23}, '{13'b00000010111,4'd11,12'd24},
		'{13'b00000011000,4'd11,12'd25}, '{13'b000011001010,4'd12,12'd26},
		'{13'b000011001011,4'd12,12'd27}, '{13'b000011001100,4'd12,12'd28},
		'{13'b000011001101,4'd12,12'd29}, '{13'b000001101000,4'd12,12'd30},
		'{13'b000001101001,4'd12,12'd31}, '{13'b000001101010,4'd12,12'd32},
		'{13'b000001101011,4'd12,12'd33}, '{13'b000011010010,4'd12,12'd34},
		'{13'b000011010011,4'd12,12'd35}, '{13'b000011010100,4'd12,12'd36},
		'{13'b000011010101,4'd12,12'd37}, '{13'b000011010110,4'd12,12'd38},
		'{13'b000011010111,4'd12,12'd39}, '{13'b000001101100,4'd12,12'd40},
		'{13'b000001101101,4'd12,12'd41}, '{13'b000011011010,4'd12,12'd42},
		'{13'b000011011011,4'd12,12'd43}, '{13'b000001010100,4'd12,12'd44},
		'{13'b000001010101,4'd12,12'd45}, '{13'b000001010110,4'd12,12'd46},
		'{13'b000001010111,4'd12,12'd47}, '{13'b000001100100,4'd12,12'd48},
		'{13'b000001100101,4'd12,12'd49}, '{13'b000001010010,4'd12,12'd50},
		'{13'b000001010011,4'd12,12'd51}, '{13'b000000100100,4'd12,12'd52},
		'{13'b000000110111,4'd12,12'd53}, '{13'b000000111000,4'd12,12'd54},
		'{13'b000000100111,4'd12,12'd55}, '{13'b000000101000,4'd12,12'd56},
		'{13'b000001011000,4'd12,12'd57}, '{13'b000001011001,4'd12,12'd58},
		'{13'b000000101011,4'd12,12'd59}, '{13'b000000101100,4'd12,12'd60},
		'{13'b000001011010,4'd12,12'd61}, '{13'b000001100110,4'd12,12'd62},
		'{13'b000001100111,4'd12,12'd63},
		'{13'b0000001111,4'd10,12'd64}, '{13'b000011001000,4'd12,12'd128},
		'{13'b000011001001,4'd12,12'd192}, '{13'b000001011011,4'd12,12'd256},
		'{13'b000000110011,4'd12,12'd320}, '{13'b000000110100,4'd12,12'd384},
		'{13'b000000110101,4'd12,12'd448}, '{13'b0000001101100,4'd13,12'd512},
		'{13'b0000001101101,4'd13,12'd576}, '{13'b0000001001010,4'd13,12'd640},
		'{13'b0000001001011,4'd13,12'd704}, '{13'b0000001001100,4'd13,12'd768},
		'{13'b0000001001101,4'd13,12'd832}, '{13'b0000001110010,4'd13,12'd896},
		'{13'b0000001110011,4'd13,12'd960}, '{13'b0000001110100,4'd13,12'd1024},
		'{13'b0000001110101,4'd13,12'd1088}, '{13'b0000001110110,4'd13,12'd1152},
		'{13'b0000001110111,4'd13,12'd1216}, '{13'b0000001010010,4'd13,12'd1280},
		'{13'b0000001010011,4'd13,12'd1344}, '{13'b0000001010100,4'd13,12'd1408},
		'{13'b0000001010101,4'd13,12'd1472}, '{13'b0000001011010,4'd13,12'd1536},
		'{13'b0000001011011,4'd13,12'd1600}, '{13'b0000001100100,4'd13,12'd1664},
		'{13'b0000001100101,4'd13,12'd1728}
	};

	localparam code_t SharedCodes [NumSharedCodes] = '{
		'{13'b00000001000,4'd11,12'd1792}, '{13'b00000001100,4'd11,12'd1856},
		'{13'b00000001101,4'd11,12'd1920}, '{13'b000000010010,4'd12,12'd1984},
		'{13'b000000010011,4'd12,12'd2048}, '{13'b000000010100,4'd12,12'd2112},
		'{13'b000000010101,4'd12,12'd2176}, '{13'b000000010110,4'd12,12'd2240},
		'{13'b000000010111,4'd12,12'd2304}, '{13'b000000011100,4'd12,12'd2368},
		'{13'b000000011101,4'd12,12'd2432}, '{13'b000000011110,4'd12,12'd2496},
		'{13'b000000011111,4'd12,12'd2560}, '{13'b00000000000,4'd11,EolRun}
	};

	// Number of leading stream bits that agree with the code word, capped at its length.
	function automatic logic [3:0] fg3_agree(input code_t e, input logic [15:0] bits);
		logic [3:0] p;
		logic stop;
		p = e.len;
		stop = 1'b0;
		for (int i = 0; i < 13; i++) begin
			if (!stop && (i < int'(e.len)) && (bits[i] != e.pat[int'(e.len) - 1 - i])) begin
				p = 4'(i);
				stop = 1'b1;
			end
		end
		return p;
	endfunction

	// The search runs nibble by nibble: a failed search drops the nibbles that
	// still had a longer code word in reach.
	function automatic lookup_t fg3_lookup(input logic [15:0] bits, input logic color);
		lookup_t r;
		code_t e;
		logic [3:0] p;
		logic [2:0] deep;
		r = '0;
		deep = '0;
		for (int i = 0; i < NumColorCodes + NumSharedCodes; i++) begin
			if (i < NumColorCodes) begin
				e = color ? BlackCodes[i] : WhiteCodes[i];
			end else begin
				e = SharedCodes[i - NumColorCodes];
			end
			p = fg3_agree(e, bits);
			if (p == e.len) begin
				r.found = 1'b1;
				r.len = e.len;
				r.run = e.run;
				r.eol = (e.run == EolRun);
			end
			for (int k = 0; k < 3; k++) begin
				if ((int'(e.len) > 4 * k + 4) && (int'(p) >= 4 * k + 4)) begin
					deep[k] = 1'b1;
				end
			end
		end
		if (!r.found) begin
			r.len = deep[2] ? 4'd12 : (deep[1] ? 4'd8 : (deep[0] ? 4'd4 : 4'd0));
		end
		return r;
	endfunction

endpackage

// File: hdl/fg3_front.sv
module fg3_front (
	input logic clk,
	input logic arst_n,
	input logic reverse,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	output logic q_valid,
	input logic q_pop,
	output logic [7:0] q_byte
);
	import fg3_pkg::*;

	logic [7:0] mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic [7:0] mirrored;
	logic do_push;
	logic do_pop;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mirrored[i] = data_byte[7 - i];
		end
	end

	assign full = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_byte = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= reverse ? mirrored : data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// File: hdl/fg3_res_fifo.sv
module fg3_res_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input fg3_pkg::event_t wr_data,
	output logic full,
	input logic pop,
	output logic empty,
	output fg3_pkg::event_t head
);
	import fg3_pkg::*;

	event_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = wr_en && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// File: hdl/fg3_engine.sv
module fg3_engine (
	input logic clk,
	input logic arst_n,
	input logic [11:0] line_width,
	input logic q_valid,
	output logic q_pop,
	input logic [7:0] q_byte,
	output logic res_wr,
	output fg3_pkg::event_t res_data,
	input logic res_full
);
	import fg3_pkg::*;

	eng_state_t state_q, state_d;
	logic [31:0] buf_q, buf_d;
	logic [5:0] cnt_q, cnt_d;
	logic color_q, color_d;
	logic [11:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [2:0] streak_q, streak_d;
	mode_t mode_q, mode_d;
	logic done_q, done_d;
	logic [2:0] evc_q, evc_d;
	event_t pend_q, pend_d;
	logic pend_v_q, pend_v_d;

	lookup_t lk;
	logic can_act;
	logic finishing;
	logic ev_v;
	event_t ev;
	logic [5:0] clamp_cnt;
	logic [3:0] drop;
	logic [11:0] width;
	logic [11:0] room;
	logic [11:0] got;

	assign lk = fg3_lookup(buf_q[15:0], color_q);
	assign can_act = (cnt_q >= FillLevel) && !done_q && (evc_q < MaxEvents);
	assign finishing = (state_q == ENG_RUN) && !can_act;
	assign q_pop = (state_q == ENG_IDLE) && q_valid;
	assign clamp_cnt = (cnt_q > 6'd24) ? 6'd24 : cnt_q;
	assign width = (line_width > MaxLineWidth) ? MaxLineWidth : line_width;
	assign room = (col_q < width) ? (width - col_q) : 12'd0;
	assign got = (lk.run < room) ? lk.run : room;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (q_valid && !done_q) begin
					state_d = ENG_RUN;
				end
			end
			ENG_RUN: begin
				if (!can_act && (!pend_v_q || !res_full)) begin
					state_d = ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		buf_d = buf_q;
		cnt_d = cnt_q;
		color_d = color_q;
		col_d = col_q;
		row_d = row_q;
		streak_d = streak_q;
		mode_d = mode_q;
		done_d = done_q;
		evc_d = evc_q;
		pend_d = pend_q;
		pend_v_d = pend_v_q;
		ev_v = 1'b0;
		ev = '0;
		ev.row = row_q;
		drop = 4'd0;
		res_wr = 1'b0;
		res_data = pend_q;
		res_data.last = 1'b0;

		unique case (state_q)
			ENG_IDLE: begin
				if (q_valid && !done_q) begin
					buf_d = buf_q | (32'(q_byte) << clamp_cnt);
					cnt_d = clamp_cnt + 6'd8;
					evc_d = 3'd0;
				end
			end
			ENG_RUN: begin
				if (can_act && !res_full) begin
					case (mode_q)
						MODE_SEEK: begin
							if (buf_q[5:0] == 6'd0) begin
								mode_d = MODE_FILL;
							end else begin
								drop = 4'd1;
							end
						end
						MODE_FILL: begin
							drop = 4'd1;
							if (buf_q[0]) begin
								color_d = 1'b0;
								mode_d = MODE_NORMAL;
								if (col_q == 12'd0) begin
									if (streak_q >= 3'd3) begin
										streak_d = 3'd4;
										done_d = 1'b1;
										ev_v = 1'b1;
										ev.kind = EV_PAGE;
									end else begin
										streak_d = streak_q + 3'd1;
									end
								end else begin
									ev_v = 1'b1;
									ev.kind = EV_LINE;
									ev.start = col_q;
									if (row_q != 16'hFFFF) begin
										row_d = row_q + 16'd1;
									end
									col_d = 12'd0;
									streak_d = 3'd0;
								end
							end
						end
						default: begin
							mode_d = MODE_NORMAL;
							if (!lk.found) begin
								ev_v = 1'b1;
								ev.kind = EV_INVALID;
								ev.start = col_q;
								drop = lk.len;
								mode_d = MODE_SEEK;
							end else begin
								drop = lk.len;
								if (lk.eol) begin
									mode_d = MODE_FILL;
								end else begin
									ev_v = 1'b1;
									ev.kind = EV_RUN;
									ev.color = color_q;
									ev.start = col_q;
									ev.length = got;
									col_d = col_q + got;
									if (lk.run < 12'd64) begin
										color_d = !color_q;
									end
								end
							end
						end
					endcase
					buf_d = buf_q >> drop;
					cnt_d = cnt_q - 6'(drop);
					// A new event retires the previous one, which therefore is not the last.
					if (ev_v) begin
						res_wr = pend_v_q;
						pend_d = ev;
						pend_v_d = 1'b1;
						evc_d = evc_q + 3'd1;
					end
				end else if (finishing && pend_v_q && !res_full) begin
					res_wr = 1'b1;
					res_data.last = 1'b1;
					pend_v_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			buf_q <= '0;
			cnt_q <= '0;
			color_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			streak_q <= '0;
			mode_q <= MODE_NORMAL;
			done_q <= 1'b0;
			evc_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			buf_q <= buf_d;
			cnt_q <= cnt_d;
			color_q <= color_d;
			col_q <= col_d;
			row_q <= row_d;
			streak_q <= streak_d;
			mode_q <= mode_d;
			done_q <= done_d;
			evc_q <= evc_d;
			pend_v_q <= pend_v_d;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'd32)
		else $error("bit count above buffer size");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("page end flag cleared");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= MaxLineWidth)
		else $error("column beyond maximum line width");

	a_no_pop_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ENG_RUN) |-> !q_pop)
		else $error("byte taken while a byte is still decoding");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ENG_IDLE) |-> !pend_v_q)
		else $error("held event left behind at end of byte");

endmodule

// File: hdl/fax_g3_run_decoder.sv
// Modified Huffman (one-dimensional) fax run decoder.
// Input: raw coded bytes enter through a queue interface; a byte is taken
// on a clock edge where push is high and full is low. A two-entry byte queue
// sits in front of the decode engine.
// Results: run, line-end, invalid-code and page-end events leave through a
// queue interface; the oldest event is on the ports while empty is low and
// is taken on an edge where pop is high. The last flag marks the final
// event produced by one input byte.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 bit order, 1 line
// width) and cfg_data; cfg_ready is always high. Write only while idle.
// Sequence: the engine loads a byte, runs its decode or skip steps and ends
// with a closing step that writes out any held event; it takes the next byte
// only after that. Bits are skipped one at a time after an invalid code.
// One shared code lookup and bit buffer serve all steps; each event is held
// until the next event or byte end, then enters the two-entry result queue.
// When the receiver stalls the result queue fills and the engine waits; the
// byte queue then fills and full rises. Reset clears all decode state,
// selects normal bit order and a line width of 1728.
module fax_g3_run_decoder (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	output logic empty,
	input logic pop,
	output logic [1:0] event_kind,
	output logic run_color,
	output logic [11:0] start_column,
	output logic [11:0] run_length,
	output logic [15:0] row_index,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [11:0] cfg_data
);
	import fg3_pkg::*;

	logic reverse_q;
	logic [11:0] width_q;
	logic q_valid;
	logic q_pop;
	logic [7:0] q_byte;
	logic res_wr;
	event_t res_data;
	logic res_full;
	event_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
			width_q <= LineWidthReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_REVERSE: reverse_q <= cfg_data[0];
				CFG_WIDTH: width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fg3_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.reverse(reverse_q),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_byte(q_byte)
	);

	fg3_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.line_width(width_q),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_byte(q_byte),
		.res_wr(res_wr),
		.res_data(res_data),
		.res_full(res_full)
	);

	fg3_res_fifo u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_wr),
		.wr_data(res_data),
		.full(res_full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	assign event_kind = head.kind;
	assign run_color = head.color;
	assign start_column = head.start;
	assign run_length = head.length;
	assign row_index = head.row;
	assign last = head.last;

endmodule

// File: test/fg3_event_checker.sv
module fg3_event_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [7:0] data_byte,
	input logic empty,
	input logic pop,
	input logic [1:0] event_kind,
	input logic run_color,
	input logic [11:0] start_column,
	input logic [11:0] run_length,
	input logic [15:0] row_index,
	input logic last,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_index,
	input logic [11:0] cfg_data,
	output int fail_count,
	output int pending
);
	import fg3_pkg::*;

	logic rev;
	logic [11:0] width;
	logic [31:0] acc;
	int nbits;
	logic color;
	int col;
	int row;
	int streak;
	mode_t mode;
	logic halted;
	event_t want_q[$];
	event_t evs[4];
	int nev;

	assign pending = want_q.size();

	task automatic probe(input code_t e, input int n, inout bit hit, inout bit deeper,
		inout int len, inout int run);
		int m;
		bit same;
		m = (int'(e.len) < n) ? int'(e.len) : n;
		same = 1'b1;
		for (int i = 0; i < m; i++) begin
			if (e.pat[int'(e.len) - 1 - i] != acc[i]) same = 1'b0;
		end
		if (same && !hit && int'(e.len) <= n) begin
			hit = 1'b1;
			len = e.len;
			run = e.run;
		end else if (same && int'(e.len) > n) begin
			deeper = 1'b1;
		end
	endtask

	// The search widens four bits at a time; when nothing longer is in reach the
	// nibbles already passed are what an invalid code drops.
	task automatic find_code(output bit ok, output int len, output int run);
		int n;
		bit deeper;
		bit hit;
		ok = 1'b0;
		len = 16;
		run = 0;
		for (int d = 0; d < 4; d++) begin
			n = 4 * d + 4;
			deeper = 1'b0;
			hit = 1'b0;
			for (int i = 0; i < NumColorCodes; i++) begin
				probe(color ? BlackCodes[i] : WhiteCodes[i], n, hit, deeper, len, run);
			end
			for (int i = 0; i < NumSharedCodes; i++) begin
				probe(SharedCodes[i], n, hit, deeper, len, run);
			end
			if (hit) begin
				ok = 1'b1;
				return;
			end
			if (!deeper) begin
				len = 4 * d;
				return;
			end
		end
		len = 16;
	endtask

	task automatic drop(input int k);
		if (k > nbits) k = nbits;
		acc = (k >= 32) ? 32'd0 : (acc >> k);
		nbits -= k;
	endtask

	task automatic add(input event_kind_t kind, input logic c, input int start, input int len);
		evs[nev].kind = kind;
		evs[nev].color = c;
		evs[nev].start = start[11:0];
		evs[nev].length = len[11:0];
		evs[nev].row = row[15:0];
		evs[nev].last = 1'b0;
		nev++;
	endtask

	task automatic close_line();
		color = 1'b0;
		mode = MODE_NORMAL;
		if (col == 0) begin
			streak++;
			if (streak >= 4) begin
				streak = 4;
				halted = 1'b1;
				add(EV_PAGE, 1'b0, 0, 0);
			end
		end else begin
			add(EV_LINE, 1'b0, col, 0);
			if (row < 65535) row++;
			col = 0;
			streak = 0;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [7:0] v;
		bit ok;
		bit one;
		int len;
		int run;
		int lim;
		int room;
		int got;
		if (halted) return;
		v = b;
		if (rev) v = {<<{b}};
		if (nbits > 24) nbits = 24;
		acc = acc | (32'(v) << nbits);
		nbits += 8;
		nev = 0;
		while (nbits >= 20 && !halted && nev < 4) begin
			if (mode == MODE_SEEK) begin
				if (acc[5:0] == 6'd0) mode = MODE_FILL;
				else drop(1);
			end else if (mode == MODE_FILL) begin
				one = acc[0];
				drop(1);
				if (one) close_line();
			end else begin
				mode = MODE_NORMAL;
				find_code(ok, len, run);
				if (!ok) begin
					add(EV_INVALID, 1'b0, col, 0);
					drop(len);
					mode = MODE_SEEK;
				end else begin
					drop(len);
					if (run == int'(EolRun)) begin
						mode = MODE_FILL;
					end else begin
						lim = (width < MaxLineWidth) ? int'(width) : int'(MaxLineWidth);
						room = (col < lim) ? lim - col : 0;
						got = (run < room) ? run : room;
						add(EV_RUN, color, col, got);
						col += got;
						if (run < 64) color = ~color;
					end
				end
			end
		end
		for (int i = 0; i < nev; i++) begin
			if (i == nev - 1) evs[i].last = 1'b1;
			want_q.push_back(evs[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		event_t w;
		if (!arst_n) begin
			rev = 1'b0;
			width = LineWidthReset;
			acc = '0;
			nbits = 0;
			color = 1'b0;
			col = 0;
			row = 0;
			streak = 0;
			mode = MODE_NORMAL;
			halted = 1'b0;
			fail_count <= 0;
			want_q.delete();
		end else begin
			if (pop && !empty) begin
				if (want_q.size() == 0) begin
					$error("event with no expectation: kind %0d", event_kind);
					fail_count <= fail_count + 1;
				end else begin
					w = want_q.pop_front();
					if (event_kind != w.kind || run_color != w.color
						|| start_column != w.start || run_length != w.length
						|| row_index != w.row || last != w.last) begin
						fail_count <= fail_count + 1;
					end
					if (event_kind != w.kind)
						$error("event_kind: expected %0d, got %0d", w.kind, event_kind);
					if (run_color != w.color)
						$error("run_color: expected %0d, got %0d", w.color, run_color);
					if (start_column != w.start)
						$error("start_column: expected %0d, got %0d", w.start, start_column);
					if (run_length != w.length)
						$error("run_length: expected %0d, got %0d", w.length, run_length);
					if (row_index != w.row)
						$error("row_index: expected %0d, got %0d", w.row, row_index);
					if (last != w.last)
						$error("last: expected %0d, got %0d", w.last, last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REVERSE) rev = cfg_data[0];
				else if (cfg_index == CFG_WIDTH) width = cfg_data;
			end
			if (push && !full) decode_byte(data_byte);
		end
	end

endmodule

// File: test/tb.sv
module tb;
	import fg3_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] data_byte = 8'd0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] event_kind;
	logic run_color;
	logic [11:0] start_column;
	logic [11:0] run_length;
	logic [15:0] row_index;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [11:0] cfg_data = 12'd0;
	int fail_count;
	int pending;

	bit stream_q[$];
	logic tb_rev = 1'b0;
	bit steady = 1'b0;
	int bytes_sent = 0;

	fax_g3_run_decoder u_dut (.*);
	fg3_event_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The receiver stalls at random except while the sender runs steady.
	initial begin
		int gap;
		forever begin
			gap = steady ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		do begin
			while (pending != 0) @(posedge clk);
			repeat (40) @(posedge clk);
		end while (pending != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic put_code(input code_t e);
		for (int i = int'(e.len) - 1; i >= 0; i--) stream_q.push_back(e.pat[i]);
	endtask

	task automatic put_eol(input int fill);
		repeat (11 + fill) stream_q.push_back(1'b0);
		stream_q.push_back(1'b1);
	endtask

	// One coded line: alternating colors, makeup codes followed by a
	// terminating code of the same color, now and then some stray bits.
	task automatic put_line();
		bit c;
		c = 1'b0;
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 7) == 0) put_code(SharedCodes[$urandom_range(0, 12)]);
				else put_code(c ? BlackCodes[$urandom_range(64, 90)]
					: WhiteCodes[$urandom_range(64, 90)]);
			end
			put_code(c ? BlackCodes[$urandom_range(0, 63)] : WhiteCodes[$urandom_range(0, 63)]);
			c = ~c;
		end
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 30)) stream_q.push_back(1'($urandom));
		end
		put_eol($urandom_range(0, 6));
	endtask

	task automatic flush_stream();
		logic [7:0] b;
		while (stream_q.size() >= 8) begin
			for (int j = 0; j < 8; j++) begin
				if (tb_rev) b[7 - j] = stream_q.pop_front();
				else b[j] = stream_q.pop_front();
			end
			send_byte(b);
		end
	endtask

	task automatic run_lines(input int count);
		int first;
		first = bytes_sent;
		while (bytes_sent - first < count) begin
			put_line();
			flush_stream();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-length run, makeup and extended makeup codes, then raw bytes that
		// decode as invalid codes followed by resynchronization.
		put_eol(0);
		put_code(WhiteCodes[0]);
		put_code(BlackCodes[2]);
		put_code(WhiteCodes[90]);
		put_code(WhiteCodes[5]);
		put_code(SharedCodes[12]);
		put_code(BlackCodes[63]);
		put_code(WhiteCodes[7]);
		put_eol(3);
		flush_stream();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'h00);
		send_byte(8'h01);
		put_eol(2);
		flush_stream();

		run_lines(80);
		wait_idle();

		tb_rev = 1'b1;
		write_reg(CFG_REVERSE, 12'd1);
		write_reg(CFG_WIDTH, 12'd2048);
		steady = 1'b1;
		run_lines(60);
		wait_idle();

		tb_rev = 1'b0;
		steady = 1'b0;
		write_reg(CFG_REVERSE, 12'd0);
		write_reg(CFG_WIDTH, 12'd1);
		run_lines(40);
		wait_idle();

		// Zero width clamps every run to nothing; keep it to a single line so
		// empty line ends cannot pile up into a page end.
		write_reg(CFG_WIDTH, 12'd0);
		put_line();
		flush_stream();
		wait_idle();

		write_reg(CFG_WIDTH, 12'd4095);
		run_lines(40);
		wait_idle();

		tb_rev = 1'b1;
		write_reg(CFG_REVERSE, 12'd1);
		write_reg(CFG_WIDTH, 12'd1728);
		run_lines(50);

		// Return to control: one real line, then empty line ends until the page
		// closes; the bytes after it are ignored.
		put_line();
		repeat (5) put_eol($urandom_range(0, 3));
		flush_stream();
		repeat (4) send_byte(8'h00);
		repeat (6) send_byte(8'($urandom));
		wait_idle();

		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
